### hw/rtl/lrbb_pkg.sv
`timescale 1ns / 1ps

package lrbb_pkg;

    localparam int unsigned MAX_PIXELS_DEFAULT = 65536;

    localparam int unsigned IDX_W     = 16;
    localparam int unsigned PIX_W     = 32;
    localparam int unsigned DIM_W     = 11;
    localparam int unsigned OFF_W     = 22;
    localparam int unsigned FRAC_W    = 5;
    localparam int unsigned YFRAC_LSB = 22;
    localparam int unsigned XFRAC_LSB = 27;
    localparam int unsigned WT_W      = 11;
    localparam int unsigned REM_W     = DIM_W;
    localparam int unsigned DIV_STEP  = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned NTAPS     = 4;

    localparam logic [DIM_W-1:0] DIM_MIN = 11'd2;
    localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

    typedef enum logic [1:0] {
        OP_WRITE_SRC = 2'd0,
        OP_WRITE_MAP = 2'd1,
        OP_PRODUCE   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH       = 3'd0,
        CFG_HEIGHT      = 3'd1,
        CFG_SUBPIXEL    = 3'd2,
        CFG_BLEND       = 3'd3,
        CFG_TABLE_VALID = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_SINGLE,
        KIND_BILIN
    } kind_t;

    typedef struct packed {
        kind_t                        kind;
        logic                         blend;
        logic [IDX_W-1:0]             idx;
        logic [PIX_W-1:0]             data;
        logic [PIX_W-1:0]             existing;
        logic [NTAPS-1:0][WT_W-1:0]   wt;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]             idx;
        logic [PIX_W-1:0]             existing;
        logic                         bilin;
        logic                         blend;
        logic [NTAPS-1:0][WT_W-1:0]   wt;
        logic [NTAPS-1:0][PIX_W-1:0]  px;
    } mix_in_t;

endpackage

### hw/rtl/lrbb_divider.sv
`timescale 1ns / 1ps

module lrbb_divider import lrbb_pkg::*; #(
    parameter int unsigned ABITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  item_t            in_item,
    input  logic [DIM_W-1:0] divisor,
    output logic             out_valid,
    output item_t            out_item,
    output logic [REM_W-1:0] out_rem
);

    localparam int unsigned NSTG = (ABITS + DIV_STEP - 1) / DIV_STEP;
    localparam int unsigned DB   = NSTG * DIV_STEP;

    function automatic logic [REM_W-1:0] rem_step(
        input logic [REM_W-1:0]    r,
        input logic [DIV_STEP-1:0] bits,
        input logic [DIM_W-1:0]    w
    );
        logic [REM_W-1:0] t;
        t = r;
        for (int k = DIV_STEP - 1; k >= 0; k--) begin
            t = {t[REM_W-2:0], bits[k]};
            if (t >= w) begin
                t = t - w;
            end
        end
        return t;
    endfunction

    logic             vld_reg [NSTG];
    item_t            itm_reg [NSTG];
    logic [REM_W-1:0] rem_reg [NSTG];

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_stage
            item_t            src_item;
            logic [REM_W-1:0] src_rem;
            logic             src_vld;
            logic [DB-1:0]    dvd;

            if (g == 0) begin : g_first
                assign src_item = in_item;
                assign src_rem  = '0;
                assign src_vld  = in_valid;
            end else begin : g_next
                assign src_item = itm_reg[g-1];
                assign src_rem  = rem_reg[g-1];
                assign src_vld  = vld_reg[g-1];
            end

            assign dvd = DB'(src_item.data[ABITS-1:0]);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[g] <= 1'b0;
                end else if (adv) begin
                    vld_reg[g] <= src_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    itm_reg[g] <= src_item;
                    rem_reg[g] <= rem_step(src_rem, dvd[DB-1-g*DIV_STEP -: DIV_STEP], divisor);
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NSTG-1];
    assign out_item  = itm_reg[NSTG-1];
    assign out_rem   = rem_reg[NSTG-1];

endmodule

### hw/rtl/lrbb_mixer.sv
`timescale 1ns / 1ps

module lrbb_mixer import lrbb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  mix_in_t          in_req,
    output logic             out_valid,
    output logic [IDX_W-1:0] out_idx,
    output logic [PIX_W-1:0] out_pixel
);

    localparam int unsigned PROD_W = 8 + WT_W;
    localparam int unsigned SUM_W  = PROD_W + 1;

    logic                                       m1_valid_reg;
    logic [NTAPS-1:0][NTAPS-1:0][PROD_W-1:0]    prod_reg;
    logic [NTAPS-1:0][NTAPS-1:0][PROD_W-1:0]    prod_next;
    logic [PIX_W-1:0]                           m1_px0_reg;
    logic [PIX_W-1:0]                           m1_exist_reg;
    logic [IDX_W-1:0]                           m1_idx_reg;
    logic                                       m1_bilin_reg;
    logic                                       m1_blend_reg;

    logic                                       m2_valid_reg;
    logic [IDX_W-1:0]                           m2_idx_reg;
    logic [PIX_W-1:0]                           m2_pix_reg;
    logic [PIX_W-1:0]                           m2_pix_next;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < NTAPS; k++) begin
                prod_next[c][k] = PROD_W'(in_req.px[k][8*c +: 8]) * PROD_W'(in_req.wt[k]);
            end
        end
    end

    always_comb begin
        logic [SUM_W-1:0] sum;
        logic [7:0]       smp;
        logic [8:0]       avg;
        m2_pix_next = '0;
        for (int c = 0; c < 4; c++) begin
            sum = SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                + SUM_W'(prod_reg[c][2]) + SUM_W'(prod_reg[c][3]) + SUM_W'(512);
            smp = m1_bilin_reg ? sum[17:10] : m1_px0_reg[8*c +: 8];
            avg = {1'b0, smp} + {1'b0, m1_exist_reg[8*c +: 8]};
            m2_pix_next[8*c +: 8] = m1_blend_reg ? avg[8:1] : smp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end else if (adv) begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg     <= prod_next;
            m1_px0_reg   <= in_req.px[0];
            m1_exist_reg <= in_req.existing;
            m1_idx_reg   <= in_req.idx;
            m1_bilin_reg <= in_req.bilin;
            m1_blend_reg <= in_req.blend;
            m2_idx_reg   <= m1_idx_reg;
            m2_pix_reg   <= m2_pix_next;
        end
    end

    assign out_valid = m2_valid_reg;
    assign out_idx   = m2_idx_reg;
    assign out_pixel = m2_pix_reg;

endmodule

### hw/rtl/lookup_remap_bilinear_blend_top.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Contents
// s_       | in        | s_tvalid / s_tready  | tuser opcode, tdata index, word, existing
// m_       | out       | m_tvalid / m_tready  | tdata index, output pixel
// cfg_     | in        | cfg_valid/cfg_ready  | register index and write data
//
// Source and map writes, table-invalid copies and plain lookups are accepted one per cycle
// unless the output stalls; a subpixel request holds the input until its four neighbors are
// read in turn on the single frame memory port. A request passes the table read, divider,
// fetch, frame read, sample and mixer stages and the output register before it is valid.
// Reset clears control state only; memories are undefined until written.
// A result waiting in the output register stalls the whole pipeline, input included, once
// the next result has reached the mixer output.

module lookup_remap_bilinear_blend_top import lrbb_pkg::*; #(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [79:0]          s_tdata,   // pixel_index, data_word, existing_pixel
    input  logic [1:0]           s_tuser,   // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // result_index, out_pixel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int unsigned ABITS = $clog2(MAX_PIXELS);
    localparam logic [32:0] MAXP  = 33'(MAX_PIXELS);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               subpix_reg;
    logic               blend_reg;
    logic               tvalid_reg;
    logic [DIM_W-1:0]   wc;
    logic [DIM_W-1:0]   hc;
    logic [2*DIM_W-1:0] lim_reg;

    logic               go;
    logic               pre_go;
    logic               accept;

    logic [1:0]         s_op;
    logic [IDX_W-1:0]   s_idx;
    logic [PIX_W-1:0]   s_data;
    logic [PIX_W-1:0]   s_exist;
    logic               s_in_rng;
    logic [ABITS-1:0]   tbl_addr;

    logic [PIX_W-1:0]   map_mem [MAX_PIXELS];
    logic [PIX_W-1:0]   tbl_q_reg;

    logic               p_valid_reg;
    logic [1:0]         p_op_reg;
    logic [IDX_W-1:0]   p_idx_reg;
    logic [PIX_W-1:0]   p_data_reg;
    logic [PIX_W-1:0]   p_exist_reg;
    logic               p_tzero_reg;
    item_t              p_item;
    logic [PIX_W-1:0]   p_entry;

    logic               d_valid;
    item_t              d_item;
    logic [REM_W-1:0]   d_rem;

    logic               f_valid_reg;
    item_t              f_item_reg;
    logic [REM_W-1:0]   f_rem_reg;
    logic [1:0]         f_cnt_reg;
    logic               f_done;
    logic               f_read;
    logic [NTAPS-1:0]   f_use;
    logic [DIM_W-1:0]   f_off;
    logic [32:0]        f_addr;
    logic               f_addr_rng;
    logic               f_idx_rng;
    logic               fr_we;
    logic               fr_re;
    logic [ABITS-1:0]   fr_addr;

    logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];
    logic [PIX_W-1:0]   frame_q_reg;

    logic               r_valid_reg;
    logic [1:0]         r_slot_reg;
    logic               r_zero_reg;
    logic               r_last_reg;
    logic [NTAPS-1:0]   r_use_reg;
    item_t              r_item_reg;

    logic [PIX_W-1:0]   sample_reg [NTAPS];

    logic               x_valid_reg;
    logic [NTAPS-1:0]   x_use_reg;
    item_t              x_item_reg;
    mix_in_t            mix_req;

    logic               mix_valid;
    logic [IDX_W-1:0]   mix_idx;
    logic [PIX_W-1:0]   mix_pixel;

    logic               o_valid_reg;
    logic               o_valid_next;
    logic [IDX_W-1:0]   o_idx_reg;
    logic [PIX_W-1:0]   o_pix_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd256;
            height_reg <= 11'd256;
            subpix_reg <= 1'b0;
            blend_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WIDTH:       width_reg  <= cfg_data;
                CFG_HEIGHT:      height_reg <= cfg_data;
                CFG_SUBPIXEL:    subpix_reg <= cfg_data[0];
                CFG_BLEND:       blend_reg  <= cfg_data[0];
                CFG_TABLE_VALID: tvalid_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign wc = (width_reg < DIM_MIN) ? DIM_MIN : ((width_reg > DIM_MAX) ? DIM_MAX : width_reg);
    assign hc = (height_reg < DIM_MIN) ? DIM_MIN :
                ((height_reg > DIM_MAX) ? DIM_MAX : height_reg);

    always_ff @(posedge aclk) begin
        lim_reg <= (2*DIM_W)'(hc - 11'd1) * (2*DIM_W)'(wc);
    end

    assign s_op     = s_tuser;
    assign s_idx    = s_tdata[15:0];
    assign s_data   = s_tdata[47:16];
    assign s_exist  = s_tdata[79:48];
    assign s_in_rng = {17'd0, s_idx} < MAXP;
    assign tbl_addr = ABITS'(s_idx);

    assign s_tready = pre_go;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (accept && s_op == OP_WRITE_MAP && s_in_rng) begin
            map_mem[tbl_addr] <= s_data;
        end
        if (accept && s_op == OP_PRODUCE && s_in_rng) begin
            tbl_q_reg <= map_mem[tbl_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (pre_go) begin
            p_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (pre_go) begin
            p_op_reg    <= s_op;
            p_idx_reg   <= s_idx;
            p_data_reg  <= s_data;
            p_exist_reg <= s_exist;
            p_tzero_reg <= !s_in_rng;
        end
    end

    assign p_entry = p_tzero_reg ? '0 : tbl_q_reg;

    always_comb begin
        logic [5:0]  ix;
        logic [5:0]  iy;
        logic [5:0]  xf;
        logic [5:0]  yf;
        logic [11:0] w00;
        logic [11:0] w10;
        logic [11:0] w01;
        logic [11:0] w11;
        xf  = {1'b0, p_entry[XFRAC_LSB +: FRAC_W]};
        yf  = {1'b0, p_entry[YFRAC_LSB +: FRAC_W]};
        ix  = 6'd32 - xf;
        iy  = 6'd32 - yf;
        w00 = {6'd0, ix} * {6'd0, iy};
        w10 = {6'd0, xf} * {6'd0, iy};
        w01 = {6'd0, ix} * {6'd0, yf};
        w11 = {6'd0, xf} * {6'd0, yf};

        p_item.idx      = p_idx_reg;
        p_item.existing = p_exist_reg;
        p_item.blend    = tvalid_reg && blend_reg;
        p_item.wt[0]    = w00[WT_W-1:0];
        p_item.wt[1]    = w10[WT_W-1:0];
        p_item.wt[2]    = w01[WT_W-1:0];
        p_item.wt[3]    = w11[WT_W-1:0];
        p_item.data     = p_data_reg;
        p_item.kind     = KIND_NONE;
        unique case (p_op_reg)
            OP_WRITE_SRC: p_item.kind = KIND_WRITE;
            OP_PRODUCE: begin
                if (!tvalid_reg) begin
                    p_item.kind = KIND_SINGLE;
                    p_item.data = PIX_W'(p_idx_reg);
                end else if (subpix_reg) begin
                    p_item.kind = KIND_BILIN;
                    p_item.data = p_entry;
                end else begin
                    p_item.kind = KIND_SINGLE;
                    p_item.data = p_entry;
                end
            end
            default: p_item.kind = KIND_NONE;
        endcase
    end

    lrbb_divider #(
        .ABITS (ABITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pre_go),
        .in_valid  (p_valid_reg && p_item.kind != KIND_NONE),
        .in_item   (p_item),
        .divisor   (wc),
        .out_valid (d_valid),
        .out_item  (d_item),
        .out_rem   (d_rem)
    );

    assign f_done = (f_item_reg.kind == KIND_BILIN) ? (f_cnt_reg == 2'd3) : 1'b1;
    assign pre_go = go && (!f_valid_reg || f_done);
    assign f_read = f_item_reg.kind == KIND_SINGLE || f_item_reg.kind == KIND_BILIN;

    always_comb begin
        logic right;
        logic down;
        right = f_rem_reg != (wc - 11'd1);
        down  = {2'd0, f_item_reg.data[OFF_W-1:0]} < {2'd0, lim_reg};
        if (f_item_reg.kind == KIND_BILIN) begin
            f_use = {right && down, down, right, 1'b1};
        end else begin
            f_use = 4'b0001;
        end
        case (f_cnt_reg)
            2'd0:    f_off = '0;
            2'd1:    f_off = 11'd1;
            2'd2:    f_off = wc;
            default: f_off = wc + 11'd1;
        endcase
        if (f_item_reg.kind == KIND_BILIN) begin
            f_addr = 33'(f_item_reg.data[OFF_W-1:0]) + 33'(f_off);
        end else begin
            f_addr = {1'b0, f_item_reg.data};
        end
    end

    assign f_addr_rng = f_addr < MAXP;
    assign f_idx_rng  = {17'd0, f_item_reg.idx} < MAXP;
    assign fr_we      = go && f_valid_reg && f_item_reg.kind == KIND_WRITE && f_idx_rng;
    assign fr_re      = go && f_valid_reg && f_read && f_addr_rng;
    assign fr_addr    = fr_we ? ABITS'(f_item_reg.idx) : ABITS'(f_addr);

    always_ff @(posedge aclk) begin
        if (fr_we) begin
            frame_mem[fr_addr] <= f_item_reg.data;
        end
        if (fr_re) begin
            frame_q_reg <= frame_mem[fr_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            f_cnt_reg   <= '0;
        end else if (pre_go) begin
            f_valid_reg <= d_valid;
            f_cnt_reg   <= '0;
        end else if (go && f_valid_reg) begin
            f_cnt_reg   <= f_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pre_go) begin
            f_item_reg <= d_item;
            f_rem_reg  <= d_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
        end else if (go) begin
            r_valid_reg <= f_valid_reg && f_read;
            x_valid_reg <= r_valid_reg && r_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            r_slot_reg <= f_cnt_reg;
            r_zero_reg <= !f_addr_rng;
            r_last_reg <= f_done;
            r_use_reg  <= f_use;
            r_item_reg <= f_item_reg;
            x_use_reg  <= r_use_reg;
            x_item_reg <= r_item_reg;
            if (r_valid_reg) begin
                sample_reg[r_slot_reg] <= r_zero_reg ? '0 : frame_q_reg;
            end
        end
    end

    always_comb begin
        mix_req.idx      = x_item_reg.idx;
        mix_req.existing = x_item_reg.existing;
        mix_req.bilin    = x_item_reg.kind == KIND_BILIN;
        mix_req.blend    = x_item_reg.blend;
        mix_req.wt       = x_item_reg.wt;
        for (int k = 0; k < NTAPS; k++) begin
            mix_req.px[k] = x_use_reg[k] ? sample_reg[k] : sample_reg[0];
        end
    end

    lrbb_mixer u_mixer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (go),
        .in_valid  (x_valid_reg),
        .in_req    (mix_req),
        .out_valid (mix_valid),
        .out_idx   (mix_idx),
        .out_pixel (mix_pixel)
    );

    assign go = !(mix_valid && o_valid_reg && !m_tready);

    always_comb begin
        o_valid_next = o_valid_reg;
        if (go && mix_valid) begin
            o_valid_next = 1'b1;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && mix_valid) begin
            o_idx_reg <= mix_idx;
            o_pix_reg <= mix_pixel;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_pix_reg, o_idx_reg};

endmodule
